@@ hw/rtl/crs_pkg.sv @@
// shared types and constants for the cache replacement simulator
`default_nettype none
package crs_pkg;

  // configuration register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_WAYS   = 3'd0;
  localparam logic [2:0] REG_SETS   = 3'd1;
  localparam logic [2:0] REG_BWORDS = 3'd2;
  localparam logic [2:0] REG_POLICY = 3'd3;
  localparam logic [2:0] REG_FULLA  = 3'd4;

  // replacement policy codes, anything above lfu is random
  localparam logic [2:0] POL_FIFO = 3'd0;
  localparam logic [2:0] POL_LIFO = 3'd1;
  localparam logic [2:0] POL_LRU  = 3'd2;
  localparam logic [2:0] POL_LFU  = 3'd3;
  localparam logic [2:0] POL_RAND = 3'd4;

  // field widths
  localparam int ADDR_BITS = 31;
  localparam int RANK_W    = 10;
  localparam int FREQ_W    = 32;
  localparam int CNT32_W   = 32;
  localparam int LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  // one tag store entry
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] block_number;
    logic [RANK_W-1:0]    insert_rank;
    logic [RANK_W-1:0]    use_rank;
    logic [FREQ_W-1:0]    use_frequency;
  } entry_t;

  // what the shared divider works on
  typedef enum logic [1:0] {
    DIV_OP_BN  = 2'd0,
    DIV_OP_SET = 2'd1,
    DIV_OP_RA  = 2'd2,
    DIV_OP_RB  = 2'd3
  } div_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic    clear_wr;
    logic    item_load;
    logic    div_start;
    div_op_t div_op;
    logic    scan_init;
    logic    scan_rd;
    logic    scan_ev;
    logic    decide;
    logic    fetch_rd;
    logic    fetch_ev;
    logic    upd_rd;
    logic    upd_wr;
    logic    finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic row_last;
    logic clear_last;
    logic fill;
    logic need_rand;
    logic fully_assoc;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/crs_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module crs_divider #(
  parameter int DV_W = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [crs_pkg::ADDR_BITS-1:0] dividend,
  input  wire logic [DV_W-1:0]               divisor,
  output logic [crs_pkg::ADDR_BITS-1:0]      quotient,
  output logic [DV_W-1:0]                    remainder,
  output logic                               done
);
  localparam int N = crs_pkg::ADDR_BITS;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]    quo;
  logic [DV_W-1:0] rem;
  logic [DV_W-1:0] dvs;
  logic [CW-1:0]   count;
  logic            busy;
  logic [DV_W:0]   trial;
  logic [DV_W:0]   diff;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, quo[N-1]};
    diff  = trial - {1'b0, dvs};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(N);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DV_W]) begin
        rem <= diff[DV_W-1:0];
        quo <= {quo[N-2:0], 1'b1};
      end else begin
        rem <= trial[DV_W-1:0];
        quo <= {quo[N-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule
`default_nettype wire

@@ hw/rtl/crs_tag_store.sv @@
// row-wide tag store memory, one set of ways per row
`default_nettype none
module crs_tag_store #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 64,
  parameter int SET_W    = 6
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [SET_W-1:0]                     waddr,
  input  wire crs_pkg::entry_t [MAX_WAYS-1:0]       wdata,
  input  wire logic                                 re,
  input  wire logic [SET_W-1:0]                     raddr,
  output crs_pkg::entry_t [MAX_WAYS-1:0]            rdata
);
  crs_pkg::entry_t [MAX_WAYS-1:0] mem [MAX_SETS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/crs_datapath.sv @@
// datapath: tag store, divider, scan and update logic, counters
`default_nettype none
module crs_datapath #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire crs_pkg::cmd_t                 cmd,
  output crs_pkg::status_t                   status,
  input  wire logic [3:0]                    ways_in_use,
  input  wire logic [6:0]                    sets_in_use,
  input  wire logic [6:0]                    block_words,
  input  wire logic [2:0]                    policy,
  input  wire logic                          fully_associative,
  input  wire logic [crs_pkg::ADDR_BITS-1:0] access_address,
  output logic                               done,
  output logic                               hit,
  output logic [5:0]                         set_index,
  output logic [2:0]                         way_index,
  output logic [31:0]                        hit_count,
  output logic [31:0]                        access_count
);
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SCNT_W = $clog2(MAX_SETS + 1);
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int CNT_W  = $clog2(MAX_SETS * MAX_WAYS + 1);
  localparam int DV_W   = (CNT_W > 7) ? CNT_W : 7;
  localparam int AB     = crs_pkg::ADDR_BITS;
  localparam int RW     = crs_pkg::RANK_W;
  localparam int FW     = crs_pkg::FREQ_W;
  localparam int LW     = crs_pkg::LFSR_W;

  typedef crs_pkg::entry_t [MAX_WAYS-1:0] row_t;

  // item context
  logic [WCNT_W-1:0] nw_q;
  logic [SCNT_W-1:0] ns_q;
  logic [CNT_W-1:0]  total_q;
  logic              fa_q;
  logic [2:0]        pol_q;
  logic [AB-1:0]     bn_q;
  logic [SET_W-1:0]  set_q;
  logic [SET_W-1:0]  g_first;
  logic [SET_W-1:0]  g_last;
  logic [SET_W-1:0]  ptr;

  // scan results
  logic [CNT_W-1:0]  n_q;
  logic              hit_q;
  logic [SET_W-1:0]  hit_set;
  logic [WAY_W-1:0]  hit_way;
  logic              empty_q;
  logic [SET_W-1:0]  empty_set;
  logic [WAY_W-1:0]  empty_way;
  logic              first_q;
  logic [FW-1:0]     best_key;
  logic [SET_W-1:0]  best_set;
  logic [WAY_W-1:0]  best_way;

  // chosen entry and its old ranks
  logic [SET_W-1:0]  ch_set;
  logic [WAY_W-1:0]  ch_way;
  logic [RW-1:0]     r_ins;
  logic [RW-1:0]     r_use;

  logic [LW-1:0]     lfsr;
  logic [LW-1:0]     lfsr_adv;

  // clamped configuration
  logic [WCNT_W-1:0] nw_c;
  logic [SCNT_W-1:0] ns_c;
  logic [6:0]        bw_c;
  logic              is_random;

  // divider hookup
  crs_pkg::div_op_t  div_op_q;
  logic [AB-1:0]     dvd;
  logic [DV_W-1:0]   dvs;
  logic [AB-1:0]     quo;
  logic [DV_W-1:0]   rem;
  logic              div_done;

  // memory hookup
  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  row_t              mem_wdata;
  logic              mem_re;
  logic [SET_W-1:0]  mem_raddr;
  row_t              rdata;

  // scan accumulation
  logic [CNT_W-1:0]  n_acc;
  logic              h_acc;
  logic [WAY_W-1:0]  hw_acc;
  logic              e_acc;
  logic [WAY_W-1:0]  ew_acc;
  logic              f_acc;
  logic              b_upd;
  logic [FW-1:0]     bk_acc;
  logic [WAY_W-1:0]  bw_acc;
  logic              hit_in_row;
  logic              empty_in_row;

  row_t              upd_row;
  row_t              fill_row;

  function automatic logic [FW-1:0] key_of(crs_pkg::entry_t e, logic [2:0] pol);
    logic [FW-1:0] k;
    case (pol)
      crs_pkg::POL_FIFO: k = FW'(e.insert_rank);
      crs_pkg::POL_LIFO: k = FW'(e.insert_rank);
      crs_pkg::POL_LRU:  k = FW'(e.use_rank);
      default:           k = e.use_frequency;
    endcase
    return k;
  endfunction

  // clamp of counts taken from configuration
  always_comb begin
    if (ways_in_use == 4'd0) begin
      nw_c = WCNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      nw_c = WCNT_W'(MAX_WAYS);
    end else begin
      nw_c = WCNT_W'(ways_in_use);
    end
    if (sets_in_use == 7'd0) begin
      ns_c = SCNT_W'(1);
    end else if (int'(sets_in_use) > MAX_SETS) begin
      ns_c = SCNT_W'(MAX_SETS);
    end else begin
      ns_c = SCNT_W'(sets_in_use);
    end
    bw_c = (block_words == 7'd0) ? 7'd1 : block_words;
  end

  assign is_random = (pol_q != crs_pkg::POL_FIFO) && (pol_q != crs_pkg::POL_LIFO) &&
                     (pol_q != crs_pkg::POL_LRU) && (pol_q != crs_pkg::POL_LFU);

  // galois lfsr step
  assign lfsr_adv = {1'b0, lfsr[LW-1:1]} ^ (lfsr[0] ? crs_pkg::LFSR_TAPS : '0);

  // divider operand select
  always_comb begin
    case (cmd.div_op)
      crs_pkg::DIV_OP_BN: begin
        dvd = access_address;
        dvs = DV_W'(bw_c);
      end
      crs_pkg::DIV_OP_SET: begin
        dvd = quo;
        dvs = DV_W'(ns_q);
      end
      crs_pkg::DIV_OP_RA: begin
        dvd = AB'(lfsr_adv);
        dvs = fa_q ? DV_W'(total_q) : DV_W'(nw_q);
      end
      default: begin
        dvd = AB'(rem);
        dvs = DV_W'(nw_q);
      end
    endcase
  end

  crs_divider #(.DV_W(DV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // scan of one row of the group
  always_comb begin
    n_acc        = n_q;
    h_acc        = 1'b0;
    hw_acc       = '0;
    e_acc        = 1'b0;
    ew_acc       = '0;
    f_acc        = first_q;
    b_upd        = 1'b0;
    bk_acc       = best_key;
    bw_acc       = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(nw_q)) begin
        if (rdata[w].valid) begin
          n_acc = n_acc + CNT_W'(1);
          if (!hit_q && !h_acc && rdata[w].block_number == bn_q) begin
            h_acc  = 1'b1;
            hw_acc = WAY_W'(w);
          end
        end else if (!empty_q && !e_acc) begin
          e_acc  = 1'b1;
          ew_acc = WAY_W'(w);
        end
        if (f_acc || ((pol_q == crs_pkg::POL_LIFO) ? key_of(rdata[w], pol_q) > bk_acc
                                                   : key_of(rdata[w], pol_q) < bk_acc)) begin
          f_acc  = 1'b0;
          b_upd  = 1'b1;
          bk_acc = key_of(rdata[w], pol_q);
          bw_acc = WAY_W'(w);
        end
      end
    end
    hit_in_row   = h_acc;
    empty_in_row = e_acc;
  end

  // rank update of one row for a hit or a replacement
  always_comb begin
    upd_row = rdata;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(nw_q) && rdata[w].valid) begin
        if (rdata[w].use_rank > r_use) begin
          upd_row[w].use_rank = rdata[w].use_rank - RW'(1);
        end
        if (!hit_q && rdata[w].insert_rank > r_ins) begin
          upd_row[w].insert_rank = rdata[w].insert_rank - RW'(1);
        end
      end
      if (ptr == ch_set && WAY_W'(w) == ch_way) begin
        upd_row[w].use_rank = RW'(n_q);
        if (hit_q) begin
          upd_row[w].use_frequency = (&rdata[w].use_frequency) ? rdata[w].use_frequency
                                     : rdata[w].use_frequency + FW'(1);
        end else begin
          upd_row[w].insert_rank   = RW'(n_q);
          upd_row[w].block_number  = bn_q;
          upd_row[w].use_frequency = FW'(1);
        end
      end
    end
  end

  // fill of an empty entry
  always_comb begin
    fill_row = rdata;
    fill_row[ch_way].valid         = 1'b1;
    fill_row[ch_way].block_number  = bn_q;
    fill_row[ch_way].insert_rank   = RW'(n_q + CNT_W'(1));
    fill_row[ch_way].use_rank      = RW'(n_q + CNT_W'(1));
    fill_row[ch_way].use_frequency = FW'(1);
  end

  // memory port select
  always_comb begin
    mem_re    = cmd.scan_rd | cmd.upd_rd | cmd.fetch_rd;
    mem_raddr = cmd.fetch_rd ? ch_set : ptr;
    mem_we    = cmd.clear_wr | cmd.upd_wr | (cmd.fetch_ev & !hit_q & empty_q);
    mem_waddr = cmd.fetch_ev ? ch_set : ptr;
    if (cmd.clear_wr) begin
      mem_wdata = '0;
    end else if (cmd.upd_wr) begin
      mem_wdata = upd_row;
    end else begin
      mem_wdata = fill_row;
    end
  end

  crs_tag_store #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS), .SET_W(SET_W)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // row pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.scan_init) begin
      ptr <= fa_q ? '0 : set_q;
    end else if (cmd.fetch_ev) begin
      ptr <= g_first;
    end else if (cmd.clear_wr || cmd.scan_ev || cmd.upd_wr) begin
      ptr <= ptr + SET_W'(1);
    end
  end

  // item context and divider results
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      nw_q    <= nw_c;
      ns_q    <= ns_c;
      total_q <= CNT_W'(ns_c) * CNT_W'(nw_c);
      fa_q    <= fully_associative;
      pol_q   <= policy;
    end
    if (cmd.div_start) begin
      div_op_q <= cmd.div_op;
    end
    if (div_done) begin
      case (div_op_q)
        crs_pkg::DIV_OP_BN: begin
          bn_q  <= quo;
          set_q <= '0;
        end
        crs_pkg::DIV_OP_SET: set_q <= SET_W'(rem);
        crs_pkg::DIV_OP_RA: begin
          ch_set <= set_q;
          ch_way <= WAY_W'(rem);
        end
        default: begin
          ch_set <= SET_W'(quo);
          ch_way <= WAY_W'(rem);
        end
      endcase
    end
    if (cmd.scan_init) begin
      g_first  <= fa_q ? '0 : set_q;
      g_last   <= fa_q ? SET_W'(ns_q - SCNT_W'(1)) : set_q;
      n_q      <= '0;
      hit_q    <= 1'b0;
      empty_q  <= 1'b0;
      first_q  <= 1'b1;
      best_key <= '0;
    end
    if (cmd.scan_ev) begin
      n_q     <= n_acc;
      first_q <= f_acc;
      if (hit_in_row) begin
        hit_q   <= 1'b1;
        hit_set <= ptr;
        hit_way <= hw_acc;
      end
      if (empty_in_row) begin
        empty_q   <= 1'b1;
        empty_set <= ptr;
        empty_way <= ew_acc;
      end
      if (b_upd) begin
        best_key <= bk_acc;
        best_set <= ptr;
        best_way <= bw_acc;
      end
    end
    if (cmd.decide) begin
      if (hit_q) begin
        ch_set <= hit_set;
        ch_way <= hit_way;
      end else if (empty_q) begin
        ch_set <= empty_set;
        ch_way <= empty_way;
      end else begin
        ch_set <= best_set;
        ch_way <= best_way;
      end
    end
    if (cmd.fetch_ev) begin
      r_ins <= rdata[ch_way].insert_rank;
      r_use <= rdata[ch_way].use_rank;
    end
  end

  // lfsr, counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr         <= crs_pkg::LFSR_SEED;
      hit_count    <= '0;
      access_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.decide && !hit_q && !empty_q && is_random) begin
        lfsr <= lfsr_adv;
      end
      if (cmd.finish) begin
        if (!(&access_count)) begin
          access_count <= access_count + 32'd1;
        end
        if (hit_q && !(&hit_count)) begin
          hit_count <= hit_count + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit       <= hit_q;
      set_index <= 6'(ch_set);
      way_index <= 3'(ch_way);
    end
  end

  // status back to the controller
  always_comb begin
    status.div_done    = div_done;
    status.row_last    = (ptr == g_last);
    status.clear_last  = (ptr == SET_W'(MAX_SETS - 1));
    status.fill        = !hit_q && empty_q;
    status.need_rand   = !hit_q && !empty_q && is_random;
    status.fully_assoc = fa_q;
  end
endmodule
`default_nettype wire

@@ hw/rtl/crs_control.sv @@
// controller state machine sequencing one access
`default_nettype none
module crs_control (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire crs_pkg::status_t status,
  output crs_pkg::cmd_t         cmd,
  output logic                  busy
);
  typedef enum logic [14:0] {
    ST_CLEAR     = 15'h0001,
    ST_IDLE      = 15'h0002,
    ST_DIV_BN    = 15'h0004,
    ST_DIV_SET   = 15'h0008,
    ST_SCAN_INIT = 15'h0010,
    ST_SCAN_RD   = 15'h0020,
    ST_SCAN_EV   = 15'h0040,
    ST_DECIDE    = 15'h0080,
    ST_DIV_RA    = 15'h0100,
    ST_DIV_RB    = 15'h0200,
    ST_FETCH_RD  = 15'h0400,
    ST_FETCH_EV  = 15'h0800,
    ST_UPD_RD    = 15'h1000,
    ST_UPD_WR    = 15'h2000,
    ST_FINISH    = 15'h4000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = crs_pkg::DIV_OP_BN;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.item_load = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = crs_pkg::DIV_OP_BN;
          state_next    = ST_DIV_BN;
        end
      end
      ST_DIV_BN: begin
        if (status.div_done) begin
          if (status.fully_assoc) begin
            state_next = ST_SCAN_INIT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_op    = crs_pkg::DIV_OP_SET;
            state_next    = ST_DIV_SET;
          end
        end
      end
      ST_DIV_SET: begin
        if (status.div_done) begin
          state_next = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_next  = status.row_last ? ST_DECIDE : ST_SCAN_RD;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.need_rand) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = crs_pkg::DIV_OP_RA;
          state_next    = ST_DIV_RA;
        end else begin
          state_next = ST_FETCH_RD;
        end
      end
      ST_DIV_RA: begin
        if (status.div_done) begin
          if (status.fully_assoc) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = crs_pkg::DIV_OP_RB;
            state_next    = ST_DIV_RB;
          end else begin
            state_next = ST_FETCH_RD;
          end
        end
      end
      ST_DIV_RB: begin
        if (status.div_done) begin
          state_next = ST_FETCH_RD;
        end
      end
      ST_FETCH_RD: begin
        cmd.fetch_rd = 1'b1;
        state_next   = ST_FETCH_EV;
      end
      ST_FETCH_EV: begin
        cmd.fetch_ev = 1'b1;
        state_next   = status.fill ? ST_FINISH : ST_UPD_RD;
      end
      ST_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_next = status.row_last ? ST_FINISH : ST_UPD_RD;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/cache_replacement_simulator.sv @@
// top level: configuration registers, controller and datapath
//
// Usage: program ways_in_use, sets_in_use, block_words, policy and
// fully_associative over the APB port (register i at byte address 4*i),
// only while busy is low and no result is pending. An access item is taken
// when start is high and busy is low; its word address is on access_address.
// One result per item appears for a single cycle with done high: hit,
// set_index, way_index and the saturating hit_count and access_count.
// Steps: the block number divide, the set select in set mode, the tag scan
// of each set in the group, the fetch of the chosen row, the rank rewrite of
// each set on a hit or replacement, and one divide for a random victim in
// set mode or two in fully associative mode. The next item can be taken in
// the cycle its result stands; a new item is not taken while one is in work,
// as the shared divider and the row-wide tag store serve one item at a time.
// Reset clears the registers to their defaults and then sweeps all MAX_SETS
// rows of the tag store, one row a cycle, with busy high.
// The receiver cannot stall: each result stands for exactly one cycle.
`default_nettype none
module cache_replacement_simulator #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [crs_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [30:0]                 access_address,
  output logic                             done,
  output logic                             hit,
  output logic [5:0]                       set_index,
  output logic [2:0]                       way_index,
  output logic [31:0]                      hit_count,
  output logic [31:0]                      access_count
);
  logic [3:0] ways_in_use;
  logic [6:0] sets_in_use;
  logic [6:0] block_words;
  logic [2:0] policy;
  logic       fully_associative;
  logic       cfg_wr;
  logic [2:0] reg_sel;

  crs_pkg::cmd_t    cmd;
  crs_pkg::status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[crs_pkg::ADDR_W-1:2];

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use       <= 4'd1;
      sets_in_use       <= 7'd1;
      block_words       <= 7'd1;
      policy            <= crs_pkg::POL_RAND;
      fully_associative <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        crs_pkg::REG_WAYS:   ways_in_use       <= pwdata[3:0];
        crs_pkg::REG_SETS:   sets_in_use       <= pwdata[6:0];
        crs_pkg::REG_BWORDS: block_words       <= pwdata[6:0];
        crs_pkg::REG_POLICY: policy            <= pwdata[2:0];
        crs_pkg::REG_FULLA:  fully_associative <= pwdata[0];
        default: ;
      endcase
    end
  end

  // configuration readback
  always_comb begin
    case (reg_sel)
      crs_pkg::REG_WAYS:   prdata = 32'(ways_in_use);
      crs_pkg::REG_SETS:   prdata = 32'(sets_in_use);
      crs_pkg::REG_BWORDS: prdata = 32'(block_words);
      crs_pkg::REG_POLICY: prdata = 32'(policy);
      crs_pkg::REG_FULLA:  prdata = 32'(fully_associative);
      default:             prdata = '0;
    endcase
  end

  crs_control u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  crs_datapath #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .ways_in_use       (ways_in_use),
    .sets_in_use       (sets_in_use),
    .block_words       (block_words),
    .policy            (policy),
    .fully_associative (fully_associative),
    .access_address    (access_address),
    .done              (done),
    .hit               (hit),
    .set_index         (set_index),
    .way_index         (way_index),
    .hit_count         (hit_count),
    .access_count      (access_count)
  );

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item accepted but block not busy");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without an item in progress");

  // a result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  // hits never outrun accesses
  a_hit_le_access: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit_count <= access_count)) else $error("hit count above access count");
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for the cache replacement simulator: directed and random accesses checked
// against a tag store predictor
`timescale 1ns / 1ps
module tb_top;

  localparam logic [2:0] POL_ODD  = 3'd7;
  localparam int NWAY = 8;
  localparam int NSET = 64;
  localparam int NENT = NWAY * NSET;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic        hit;
    logic [5:0]  set_idx;
    logic [2:0]  way_idx;
    logic [31:0] hits;
    logic [31:0] accesses;
  } lookup_t;

  // tag store predictor and queue of expected lookups
  class cache_scoreboard;
    logic [3:0]  ways_r;
    logic [6:0]  sets_r;
    logic [6:0]  bw_r;
    logic [2:0]  pol_r;
    logic        fa_r;
    bit          vld[NENT];
    logic [30:0] bnum[NENT];
    logic [9:0]  irank[NENT];
    logic [9:0]  urank[NENT];
    logic [31:0] freq[NENT];
    logic [31:0] hits_r, accs_r;
    logic [15:0] lfsr;
    int          g_s0, g_s1, g_nw;
    lookup_t     pending[$];
    int          errors;

    function new();
      for (int e = 0; e < NENT; e++) begin
        vld[e] = 0; bnum[e] = '0; irank[e] = '0; urank[e] = '0; freq[e] = '0;
      end
      hits_r = '0; accs_r = '0; lfsr = crs_pkg::LFSR_SEED;
      ways_r = 1; sets_r = 1; bw_r = 1; pol_r = crs_pkg::POL_RAND; fa_r = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        crs_pkg::REG_WAYS:   ways_r = v[3:0];
        crs_pkg::REG_SETS:   sets_r = v[6:0];
        crs_pkg::REG_BWORDS: bw_r = v[6:0];
        crs_pkg::REG_POLICY: pol_r = v[2:0];
        crs_pkg::REG_FULLA:  fa_r = v[0];
        default: ;
      endcase
    endfunction

    function int clampc(int v, int maxv);
      if (v == 0) return 1;
      return v > maxv ? maxv : v;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // lower ranks above the chosen entry, then put it on top
    function void rerank(bit use_ranks, int ce, int top);
      logic [9:0] r;
      int e;
      r = use_ranks ? urank[ce] : irank[ce];
      for (int s = g_s0; s < g_s1; s++)
        for (int w = 0; w < g_nw; w++) begin
          e = s * NWAY + w;
          if (use_ranks) begin
            if (vld[e] && urank[e] > r) urank[e] = urank[e] - 10'd1;
          end else if (vld[e] && irank[e] > r) irank[e] = irank[e] - 10'd1;
        end
      if (use_ranks) urank[ce] = top[9:0];
      else irank[ce] = top[9:0];
    endfunction

    function logic [31:0] key_of(logic [2:0] pol, int e);
      case (pol)
        crs_pkg::POL_FIFO, crs_pkg::POL_LIFO: return {22'd0, irank[e]};
        crs_pkg::POL_LRU:                     return {22'd0, urank[e]};
        default:                              return freq[e];
      endcase
    endfunction

    // first entry in scan order with the least or greatest key
    function int pick_extreme(logic [2:0] pol);
      int best, e;
      logic [31:0] bv;
      best = g_s0 * NWAY;
      bv = key_of(pol, best);
      for (int s = g_s0; s < g_s1; s++)
        for (int w = 0; w < g_nw; w++) begin
          e = s * NWAY + w;
          if (pol == crs_pkg::POL_LIFO ? key_of(pol, e) > bv : key_of(pol, e) < bv) begin
            best = e; bv = key_of(pol, e);
          end
        end
      return best;
    endfunction

    function int pick_random(int ns);
      int k;
      bit lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ crs_pkg::LFSR_TAPS;
      if (fa_r) begin
        k = int'(lfsr) % (ns * g_nw);
        return (k / g_nw) * NWAY + (k % g_nw);
      end
      return g_s0 * NWAY + int'(lfsr) % g_nw;
    endfunction

    // accepted access: update the tag store and queue the expected lookup
    function void note_access(logic [30:0] addr);
      int nw, ns, bw, n, chosen, e;
      logic [30:0] bn;
      bit is_hit, found_empty;
      lookup_t res;
      nw = clampc(ways_r, NWAY);
      ns = clampc(sets_r, NSET);
      bw = (bw_r == 0) ? 1 : bw_r;
      bn = 31'(addr / bw);
      n = 0; chosen = 0; is_hit = 0; found_empty = 0;
      if (fa_r) begin
        g_s0 = 0; g_s1 = ns;
      end else begin
        g_s0 = int'(bn % ns); g_s1 = g_s0 + 1;
      end
      g_nw = nw;
      accs_r = sat_inc(accs_r);
      for (int s = g_s0; s < g_s1; s++)
        for (int w = 0; w < nw; w++) begin
          e = s * NWAY + w;
          if (vld[e]) begin
            n++;
            if (!is_hit && bnum[e] == bn) begin
              is_hit = 1; chosen = e;
            end
          end else if (!found_empty) begin
            found_empty = 1;
            if (!is_hit) chosen = e;
          end
        end
      if (is_hit) begin
        hits_r = sat_inc(hits_r);
        freq[chosen] = sat_inc(freq[chosen]);
        rerank(1, chosen, n);
      end else if (found_empty) begin
        vld[chosen] = 1;
        bnum[chosen] = bn;
        irank[chosen] = 10'(n + 1);
        urank[chosen] = 10'(n + 1);
        freq[chosen] = 32'd1;
      end else begin
        if (pol_r <= crs_pkg::POL_LFU) chosen = pick_extreme(pol_r);
        else chosen = pick_random(ns);
        rerank(0, chosen, n);
        rerank(1, chosen, n);
        bnum[chosen] = bn;
        freq[chosen] = 32'd1;
      end
      res.hit = is_hit;
      res.set_idx = 6'(chosen / NWAY);
      res.way_idx = 3'(chosen % NWAY);
      res.hits = hits_r;
      res.accesses = accs_r;
      pending = {pending, res};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_lookup(lookup_t got);
      lookup_t exp;
      if (pending.size() == 0) begin
        report("lookup result with no access outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit)
        report($sformatf("hit %0b, expected %0b", got.hit, exp.hit));
      if (got.set_idx !== exp.set_idx)
        report($sformatf("set_index %0d, expected %0d", got.set_idx, exp.set_idx));
      if (got.way_idx !== exp.way_idx)
        report($sformatf("way_index %0d, expected %0d", got.way_idx, exp.way_idx));
      if (got.hits !== exp.hits)
        report($sformatf("hit_count %0d, expected %0d", got.hits, exp.hits));
      if (got.accesses !== exp.accesses)
        report($sformatf("access_count %0d, expected %0d", got.accesses, exp.accesses));
    endtask
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [crs_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic start, busy;
  logic [30:0] access_address;
  logic done, hit;
  logic [5:0] set_index;
  logic [2:0] way_index;
  logic [31:0] hit_count, access_count;

  cache_replacement_simulator u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .access_address(access_address),
    .done(done), .hit(hit), .set_index(set_index), .way_index(way_index),
    .hit_count(hit_count), .access_count(access_count)
  );

  cache_scoreboard sb;
  bit quiet;
  int stall_cycles;
  int span;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sample accepted items and results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_access(access_address);
      if (done) sb.check_lookup({hit, set_index, way_index, hit_count, access_count});
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task apb_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // wait until every lookup is back and the block is idle
  task drain();
    @(posedge clk);
    start <= 0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  task send_access(logic [30:0] a);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start <= 1;
    access_address <= a;
    do @(posedge clk); while (busy);
  endtask

  task configure(int w, int s, int b, logic [2:0] p, bit f);
    drain();
    apb_write(crs_pkg::REG_WAYS, w);
    apb_write(crs_pkg::REG_SETS, s);
    apb_write(crs_pkg::REG_BWORDS, b);
    apb_write(crs_pkg::REG_POLICY, 32'(p));
    apb_write(crs_pkg::REG_FULLA, 32'(f));
    // address window about one and a half times the store in use
    span = sb.clampc(w, NWAY) * sb.clampc(s, NSET) * (b == 0 ? 1 : b);
    if (!f) span = span + span / 2 + 1;
    else span = span + span / 2 + 1;
  endtask

  // mostly a recurring window of blocks, sometimes any address
  task random_accesses(int count);
    logic [30:0] base;
    base = 31'($urandom());
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_access(31'($urandom()));
      else send_access(31'(base + $urandom_range(0, span)));
    end
  endtask

  initial begin
    sb = new();
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; access_address = '0; quiet = 0; stall_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // defaults: one entry, random victim; miss, hit, replacement at extremes
    send_access(31'h0);
    send_access(31'h0);
    send_access(31'h7FFF_FFFF);
    send_access(31'h7FFF_FFFF);
    send_access(31'h0);
    // each policy on a two-way set, all ways filled, one hit, then one evicted
    for (int p = 0; p <= 4; p++) begin
      configure(2, 1, 1, 3'(p), 0);
      send_access(31'd10); send_access(31'd11); send_access(31'd10);
      send_access(31'd12);
    end
    // zero counts act as one, odd policy code acts as random
    configure(0, 0, 0, POL_ODD, 1);
    send_access(31'd5);
    send_access(31'd6);

    // random phases, extremes first
    configure(8, 64, 1, crs_pkg::POL_LFU, 1);    random_accesses(60);
    configure(15, 127, 127, crs_pkg::POL_LRU, 0); random_accesses(60);
    configure(1, 1, 64, crs_pkg::POL_FIFO, 0);    random_accesses(40);
    configure(4, 16, 3, crs_pkg::POL_LIFO, 1);    random_accesses(60);
    configure(8, 64, 64, crs_pkg::POL_RAND, 0);   random_accesses(60);
    configure(2, 4, 1, POL_ODD, 1);               random_accesses(60);
    for (int ph = 0; ph < 12; ph++) begin
      configure($urandom_range(0, 15), $urandom_range(0, 20), $urandom_range(0, 127),
                3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      random_accesses(60);
    end
    // final stretch with no gaps
    quiet = 1;
    configure(4, 8, 2, crs_pkg::POL_LRU, 0);
    random_accesses(100);

    drain();
    repeat (400) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("expected lookups never returned");
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
